[sv/sqt_pkg.sv]
`default_nettype none
package sqt_pkg;

  localparam int unsigned WordBufChars = 8;
  localparam int unsigned WordIdxW     = $clog2(WordBufChars);
  localparam int unsigned WordLenW     = $clog2(WordBufChars + 2);
  localparam int unsigned NumWords     = 12;
  localparam int unsigned MaxResults   = 3;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrW     = $clog2(FifoDepth);
  localparam int unsigned FifoCntW     = $clog2(FifoDepth + 1);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_DASH, M_STR, M_INT, M_INT_DOT, M_NUM,
    M_IDENT, M_DOLLAR, M_NAMED, M_BANG, M_LT, M_GT
  } mode_e;

  typedef enum logic [4:0] {
    K_EOF, K_STR, K_INT, K_NUM, K_IDENT, K_KEYWORD, K_NULL, K_NAMED,
    K_NEQ, K_LTE, K_GTE, K_LPAREN, K_RPAREN, K_COMMA, K_SEMI, K_STAR,
    K_DOT, K_EQ, K_LT, K_GT, K_PARAM, K_ERROR
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [3:0]   kw;
    logic [31:0]  eoff;
    logic [31:0]  elen;
    logic [31:0]  toff;
    logic [31:0]  tlen;
    logic [63:0]  ival;
    logic         neg;
  } tok_t;

  typedef struct packed {
    logic [1:0]   n;
    tok_t [MaxResults-1:0] tok;
  } push_t;

  typedef struct packed {
    tok_t tok;
    logic last;
  } entry_t;

  // Words right-aligned, first character in the highest used byte; NULL first.
  localparam logic [63:0] WordText [NumWords] = '{
    64'h0000_0000_6e75_6c6c, 64'h0000_0000_6a6f_696e, 64'h0000_0000_0000_6f6e,
    64'h0000_0000_0000_6173, 64'h0000_0000_0000_696e, 64'h0000_6578_6973_7473,
    64'h0000_0000_006e_6f74, 64'h0062_6574_7765_656e, 64'h0000_0000_6c65_6674,
    64'h0000_0072_6967_6874, 64'h0000_0000_6675_6c6c, 64'h0000_006f_7574_6572
  };
  localparam int unsigned WordLen [NumWords] = '{4, 4, 2, 2, 2, 6, 3, 7, 4, 5, 4, 5};

  function automatic tok_t make_tok(kind_e kind, logic [3:0] kw, logic [31:0] off,
                                    logic [31:0] len, logic [31:0] toff,
                                    logic [31:0] tlen, logic [63:0] val, logic neg);
    tok_t t;
    t.kind = kind;
    t.kw   = kw;
    t.eoff = off;
    t.elen = len;
    t.toff = toff;
    t.tlen = tlen;
    t.ival = val;
    t.neg  = neg;
    return t;
  endfunction

  function automatic tok_t simple_tok(kind_e kind, logic [31:0] off, logic [31:0] len);
    return make_tok(kind, 4'd0, off, len, off, len, 64'd0, 1'b0);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic word_start(logic [7:0] b);
    return is_alpha(b) || b == 8'h5f;
  endfunction

  function automatic logic word_cont(logic [7:0] b);
    return word_start(b) || is_digit(b);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

endpackage
`default_nettype wire

[sv/sqt_lexer.sv]
`default_nettype none
module sqt_lexer (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic         cmd_i,
  input  wire logic [7:0]   byte_i,
  output sqt_pkg::push_t    push_o
);

  sqt_pkg::mode_e mode_q, mode_d;
  logic [31:0] pos_q, pos_d, start_q, start_d;
  logic [63:0] acc_q, acc_d;
  logic        minus_q, minus_d;
  logic [sqt_pkg::WordLenW-1:0] wlen_q, wlen_d;
  logic [7:0]  wbuf_q [sqt_pkg::WordBufChars];

  logic        buf_we;
  logic [sqt_pkg::WordIdxW-1:0] buf_idx;
  logic [7:0]  buf_data;
  logic [1:0]  n;
  logic        redo;
  logic [7:0]  b, fold;
  logic [63:0] int_val;
  logic [3:0]  digit;
  sqt_pkg::tok_t word_tok;
  sqt_pkg::tok_t [sqt_pkg::MaxResults-1:0] toks;

  assign b       = byte_i;
  assign fold    = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
  assign digit   = b[3:0] - 4'd0;
  assign int_val = minus_q ? 64'd0 - acc_q : acc_q;

  // Keyword lookup over the folded buffer; a too-long word never matches.
  always_comb begin
    logic hit;
    logic found;
    word_tok = sqt_pkg::simple_tok(sqt_pkg::K_IDENT, start_q, pos_q - start_q);
    found = 1'b0;
    for (int k = 0; k < sqt_pkg::NumWords; k++) begin
      hit = (wlen_q == sqt_pkg::WordLenW'(sqt_pkg::WordLen[k]));
      for (int i = 0; i < sqt_pkg::WordBufChars; i++) begin
        if (i < sqt_pkg::WordLen[k] &&
            wbuf_q[i] != sqt_pkg::WordText[k][8*((sqt_pkg::WordLen[k]+7-i)%8) +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit && !found) begin
        found = 1'b1;
        if (k == 0) begin
          word_tok.kind = sqt_pkg::K_NULL;
        end else begin
          word_tok.kind = sqt_pkg::K_KEYWORD;
          word_tok.kw   = 4'(k - 1);
        end
      end
    end
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    acc_d    = acc_q;
    minus_d  = minus_q;
    wlen_d   = wlen_q;
    buf_we   = 1'b0;
    buf_idx  = wlen_q[sqt_pkg::WordIdxW-1:0];
    buf_data = fold;
    n        = 2'd0;
    redo     = 1'b0;
    toks     = '0;
    if (cmd_i) begin
      case (mode_q)
        sqt_pkg::M_DASH, sqt_pkg::M_DOLLAR, sqt_pkg::M_BANG: begin
          toks[n] = sqt_pkg::simple_tok(sqt_pkg::K_ERROR, start_q, 32'd1); n = n + 2'd1;
        end
        sqt_pkg::M_STR: begin
          toks[n] = sqt_pkg::make_tok(sqt_pkg::K_STR, 4'd0, start_q, pos_q - start_q,
                                      start_q + 32'd1, pos_q - start_q - 32'd1, 64'd0, 1'b0);
          n = n + 2'd1;
        end
        sqt_pkg::M_INT: begin
          toks[n] = sqt_pkg::make_tok(sqt_pkg::K_INT, 4'd0, start_q, pos_q - start_q,
                                      start_q, pos_q - start_q, int_val, minus_q);
          n = n + 2'd1;
        end
        sqt_pkg::M_INT_DOT: begin
          toks[n] = sqt_pkg::make_tok(sqt_pkg::K_INT, 4'd0, start_q, pos_q - 32'd1 - start_q,
                                      start_q, pos_q - 32'd1 - start_q, int_val, minus_q);
          n = n + 2'd1;
          toks[n] = sqt_pkg::simple_tok(sqt_pkg::K_DOT, pos_q - 32'd1, 32'd1); n = n + 2'd1;
        end
        sqt_pkg::M_NUM: begin
          toks[n] = sqt_pkg::simple_tok(sqt_pkg::K_NUM, start_q, pos_q - start_q);
          n = n + 2'd1;
        end
        sqt_pkg::M_IDENT: begin
          toks[n] = word_tok; n = n + 2'd1;
        end
        sqt_pkg::M_NAMED: begin
          toks[n] = sqt_pkg::make_tok(sqt_pkg::K_NAMED, 4'd0, start_q, pos_q - start_q,
                                      start_q + 32'd1, pos_q - start_q - 32'd1, 64'd0, 1'b0);
          n = n + 2'd1;
        end
        sqt_pkg::M_LT: begin
          toks[n] = sqt_pkg::simple_tok(sqt_pkg::K_LT, start_q, 32'd1); n = n + 2'd1;
        end
        sqt_pkg::M_GT: begin
          toks[n] = sqt_pkg::simple_tok(sqt_pkg::K_GT, start_q, 32'd1); n = n + 2'd1;
        end
        default: ;
      endcase
      toks[n] = sqt_pkg::simple_tok(sqt_pkg::K_EOF, pos_q, 32'd0); n = n + 2'd1;
      mode_d  = sqt_pkg::M_IDLE;
      pos_d   = 32'd0;
      start_d = 32'd0;
      acc_d   = 64'd0;
      minus_d = 1'b0;
      wlen_d  = '0;
    end else begin
      pos_d = pos_q + 32'd1;
      case (mode_q)
        sqt_pkg::M_COMMENT: if (b == 8'h0a) mode_d = sqt_pkg::M_IDLE;
        sqt_pkg::M_DASH: begin
          if (b == 8'h2d) begin
            mode_d = sqt_pkg::M_COMMENT;
          end else if (sqt_pkg::is_digit(b)) begin
            mode_d = sqt_pkg::M_INT; acc_d = 64'(digit); minus_d = 1'b1;
          end else begin
            toks[n] = sqt_pkg::simple_tok(sqt_pkg::K_ERROR, start_q, 32'd1);
            n = n + 2'd1; redo = 1'b1;
          end
        end
        sqt_pkg::M_STR: begin
          if (b == 8'h27) begin
            toks[n] = sqt_pkg::make_tok(sqt_pkg::K_STR, 4'd0, start_q,
                                        pos_q + 32'd1 - start_q, start_q + 32'd1,
                                        pos_q - start_q - 32'd1, 64'd0, 1'b0);
            n = n + 2'd1;
            mode_d = sqt_pkg::M_IDLE;
          end
        end
        sqt_pkg::M_INT: begin
          if (sqt_pkg::is_digit(b)) begin
            acc_d = (acc_q << 3) + (acc_q << 1) + 64'(digit);
          end else if (b == 8'h2e) begin
            mode_d = sqt_pkg::M_INT_DOT;
          end else begin
            toks[n] = sqt_pkg::make_tok(sqt_pkg::K_INT, 4'd0, start_q, pos_q - start_q,
                                        start_q, pos_q - start_q, int_val, minus_q);
            n = n + 2'd1; redo = 1'b1;
          end
        end
        sqt_pkg::M_INT_DOT: begin
          if (sqt_pkg::is_digit(b)) begin
            mode_d = sqt_pkg::M_NUM;
          end else begin
            toks[n] = sqt_pkg::make_tok(sqt_pkg::K_INT, 4'd0, start_q,
                                        pos_q - 32'd1 - start_q, start_q,
                                        pos_q - 32'd1 - start_q, int_val, minus_q);
            n = n + 2'd1;
            toks[n] = sqt_pkg::simple_tok(sqt_pkg::K_DOT, pos_q - 32'd1, 32'd1);
            n = n + 2'd1; redo = 1'b1;
          end
        end
        sqt_pkg::M_NUM: begin
          if (!sqt_pkg::is_digit(b)) begin
            toks[n] = sqt_pkg::simple_tok(sqt_pkg::K_NUM, start_q, pos_q - start_q);
            n = n + 2'd1; redo = 1'b1;
          end
        end
        sqt_pkg::M_IDENT: begin
          if (sqt_pkg::word_cont(b)) begin
            // hold the count one past full so a long word cannot match
            if (wlen_q < sqt_pkg::WordLenW'(sqt_pkg::WordBufChars)) begin
              buf_we = 1'b1; wlen_d = wlen_q + 1'b1;
            end else if (wlen_q == sqt_pkg::WordLenW'(sqt_pkg::WordBufChars)) begin
              wlen_d = wlen_q + 1'b1;
            end
          end else begin
            toks[n] = word_tok; n = n + 2'd1; redo = 1'b1;
          end
        end
        sqt_pkg::M_DOLLAR: begin
          if (sqt_pkg::word_start(b)) begin
            mode_d = sqt_pkg::M_NAMED;
          end else begin
            toks[n] = sqt_pkg::simple_tok(sqt_pkg::K_ERROR, start_q, 32'd1);
            n = n + 2'd1; redo = 1'b1;
          end
        end
        sqt_pkg::M_NAMED: begin
          if (!sqt_pkg::word_cont(b)) begin
            toks[n] = sqt_pkg::make_tok(sqt_pkg::K_NAMED, 4'd0, start_q, pos_q - start_q,
                                        start_q + 32'd1, pos_q - start_q - 32'd1,
                                        64'd0, 1'b0);
            n = n + 2'd1; redo = 1'b1;
          end
        end
        sqt_pkg::M_BANG, sqt_pkg::M_LT, sqt_pkg::M_GT: begin
          if (b == 8'h3d) begin
            toks[n] = sqt_pkg::simple_tok(mode_q == sqt_pkg::M_BANG ? sqt_pkg::K_NEQ :
                                          mode_q == sqt_pkg::M_LT ? sqt_pkg::K_LTE :
                                          sqt_pkg::K_GTE, start_q, 32'd2);
            n = n + 2'd1; mode_d = sqt_pkg::M_IDLE;
          end else begin
            toks[n] = sqt_pkg::simple_tok(mode_q == sqt_pkg::M_BANG ? sqt_pkg::K_ERROR :
                                          mode_q == sqt_pkg::M_LT ? sqt_pkg::K_LT :
                                          sqt_pkg::K_GT, start_q, 32'd1);
            n = n + 2'd1; redo = 1'b1;
          end
        end
        default: redo = 1'b1;
      endcase
      // rescan the ending byte as the first byte after the token
      if (redo) begin
        mode_d  = sqt_pkg::M_IDLE;
        start_d = pos_q;
        if (sqt_pkg::is_space(b)) begin
          mode_d = sqt_pkg::M_IDLE;
        end else if (b == 8'h27) begin
          mode_d = sqt_pkg::M_STR;
        end else if (sqt_pkg::is_digit(b)) begin
          mode_d = sqt_pkg::M_INT; acc_d = 64'(digit); minus_d = 1'b0;
        end else if (sqt_pkg::word_start(b)) begin
          mode_d = sqt_pkg::M_IDENT; buf_we = 1'b1; buf_idx = '0;
          wlen_d = sqt_pkg::WordLenW'(1);
        end else begin
          case (b)
            8'h2d: mode_d = sqt_pkg::M_DASH;
            8'h24: mode_d = sqt_pkg::M_DOLLAR;
            8'h21: mode_d = sqt_pkg::M_BANG;
            8'h3c: mode_d = sqt_pkg::M_LT;
            8'h3e: mode_d = sqt_pkg::M_GT;
            default: begin
              toks[n] = sqt_pkg::simple_tok(
                b == 8'h28 ? sqt_pkg::K_LPAREN : b == 8'h29 ? sqt_pkg::K_RPAREN :
                b == 8'h2c ? sqt_pkg::K_COMMA  : b == 8'h3b ? sqt_pkg::K_SEMI :
                b == 8'h2a ? sqt_pkg::K_STAR   : b == 8'h2e ? sqt_pkg::K_DOT :
                b == 8'h3d ? sqt_pkg::K_EQ     : b == 8'h3f ? sqt_pkg::K_PARAM :
                sqt_pkg::K_ERROR, pos_q, 32'd1);
              n = n + 2'd1;
            end
          endcase
        end
      end
    end
  end

  assign push_o.n   = accept_i ? n : 2'd0;
  assign push_o.tok = toks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sqt_pkg::M_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      acc_q   <= '0;
      minus_q <= 1'b0;
      wlen_q  <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      acc_q   <= acc_d;
      minus_q <= minus_d;
      wlen_q  <= wlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !cmd_i && buf_we) begin
      wbuf_q[buf_idx] <= buf_data;
    end
  end

endmodule
`default_nettype wire

[sv/sqt_result_fifo.sv]
`default_nettype none
module sqt_result_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  sqt_pkg::push_t       push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output sqt_pkg::entry_t      entry_o
);

  sqt_pkg::entry_t mem_q [sqt_pkg::FifoDepth];
  logic [sqt_pkg::FifoPtrW-1:0] wr_q, rd_q;
  logic [sqt_pkg::FifoCntW-1:0] cnt_q, cnt_d;
  logic pop;

  assign valid_o = cnt_q != '0;
  assign pop     = pop_i && valid_o;
  assign room_o  = cnt_q <= sqt_pkg::FifoCntW'(sqt_pkg::FifoDepth - sqt_pkg::MaxResults);
  assign entry_o = mem_q[rd_q];
  assign cnt_d   = cnt_q + sqt_pkg::FifoCntW'(push_i.n) - sqt_pkg::FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + sqt_pkg::FifoPtrW'(push_i.n);
      rd_q  <= rd_q + sqt_pkg::FifoPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < sqt_pkg::MaxResults; j++) begin
      if (j < int'(push_i.n)) begin
        mem_q[wr_q + sqt_pkg::FifoPtrW'(j)].tok  <= push_i.tok[j];
        mem_q[wr_q + sqt_pkg::FifoPtrW'(j)].last <= (j == int'(push_i.n) - 1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> room_o)
    else $error("result push without room");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + sqt_pkg::FifoCntW'($past(push_i.n))
             - sqt_pkg::FifoCntW'($past(pop)))
    else $error("result count drift");
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sqt_pkg::FifoCntW'(sqt_pkg::FifoDepth))
    else $error("result count above depth");
`endif

endmodule
`default_nettype wire

[sv/sql_query_tokenizer.sv]
// SQL tokenizer, stream in, stream out.
// Input requests carry one source byte in s_axis_tdata_i with s_axis_tuser_i
// low, or an end-of-source command with s_axis_tuser_i high. The end command
// flushes any pending token, emits EOF and returns the lexer to offset zero.
// Each request yields zero to three tokens on the output stream; m_axis_tlast_o
// marks the last token caused by one request. Whitespace and line comments
// yield nothing.
// Each token is written into the result queue when the request completing it
// is accepted and is sent after any earlier tokens. Throughput: one request per
// cycle while each yields at most one token and the output is not stalled;
// requests yielding two or three tokens are limited by the output stream at one
// token per cycle, set by the four-entry result queue. The input side is ready
// while the queue holds at most one token, so a stall at the receiver backs up
// into the input after at most four queued tokens. Reset clears the lexer state
// and empties the queue; nothing is lost or repeated across output stalls.
`default_nettype none
module sql_query_tokenizer (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire logic [7:0]     s_axis_tdata_i,   // src_byte
  input  wire logic           s_axis_tuser_i,   // cmd
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  // keyword_index, extent_offset, extent_length, text_offset, text_length,
  // integer_value, is_negative, zero fill
  output logic [199:0]        m_axis_tdata_o,
  output logic [4:0]          m_axis_tuser_o,   // token_kind
  output logic                m_axis_tlast_o    // last_of_run
);

  logic            accept;
  sqt_pkg::push_t  push;
  sqt_pkg::entry_t entry;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  sqt_lexer u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (s_axis_tuser_i),
    .byte_i   (s_axis_tdata_i),
    .push_o   (push)
  );

  sqt_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .pop_i   (m_axis_tready_i),
    .entry_o (entry)
  );

  assign m_axis_tuser_o = entry.tok.kind;
  assign m_axis_tlast_o = entry.last;
  assign m_axis_tdata_o = {3'b000, entry.tok.neg, entry.tok.ival, entry.tok.tlen,
                           entry.tok.toff, entry.tok.elen, entry.tok.eoff, entry.tok.kw};

endmodule
`default_nettype wire
